[hdl/dbq_pkg.sv]
// ----------------------------------------------------------------------------
// dbq_pkg - shared types and constants of the bounded deque
// Sizes, operation and status codes, memory port bundle, slot arithmetic.
// ----------------------------------------------------------------------------
package dbq_pkg;

	localparam int CAPACITY    = 16;
	localparam int DATA_WIDTH  = 32;
	localparam int ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int COUNT_W     = $clog2(CAPACITY + 1);
	localparam int SUM_W       = COUNT_W + 1;
	localparam int OP_W        = 3;
	localparam int IN_VALUE_W  = 32;
	localparam int OUT_DATA_W  = 32;
	localparam int OUT_COUNT_W = 5;
	localparam int STATUS_W    = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_PEEK_FRONT = 3'd4,
		OP_PEEK_BACK  = 3'd5,
		OP_CONTAINS   = 3'd6,
		OP_REMOVE     = 3'd7
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_SHIFT_RD,
		ST_SHIFT_WR
	} state_t;

	// single-port store access, one read or one write per cycle
	typedef struct packed {
		logic                  rd_en;
		logic                  wr_en;
		logic [ADDR_W-1:0]     addr;
		logic [DATA_WIDTH-1:0] wdata;
	} mem_req_t;

	// slot of the k-th value from the front; front and k both below CAPACITY
	function automatic logic [ADDR_W-1:0] slot_of(logic [ADDR_W-1:0] front,
		logic [COUNT_W-1:0] k);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(front) + SUM_W'(k);
		if (sum >= SUM_W'(CAPACITY)) begin
			sum = sum - SUM_W'(CAPACITY);
		end
		return ADDR_W'(sum);
	endfunction

endpackage

[hdl/dbq_req_if.sv]
// ----------------------------------------------------------------------------
// dbq_req_if - operation channel of the bounded deque
// valid/ready handshake carrying the operation code and its value.
// ----------------------------------------------------------------------------
interface dbq_req_if;
	import dbq_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [OP_W-1:0]       operation;
	logic [IN_VALUE_W-1:0] value;

	modport source (output valid, output operation, output value, input ready);
	modport sink   (input valid, input operation, input value, output ready);
endinterface

[hdl/dbq_rsp_if.sv]
// ----------------------------------------------------------------------------
// dbq_rsp_if - result channel of the bounded deque
// valid/ready handshake carrying data, found flag, status and entry count.
// ----------------------------------------------------------------------------
interface dbq_rsp_if;
	import dbq_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [OUT_DATA_W-1:0]  data;
	logic                   found;
	logic [STATUS_W-1:0]    status;
	logic [OUT_COUNT_W-1:0] entry_count;

	modport source (output valid, output data, output found, output status,
		output entry_count, input ready);
	modport sink   (input valid, input data, input found, input status,
		input entry_count, output ready);
endinterface

[hdl/dbq_store.sv]
// ----------------------------------------------------------------------------
// dbq_store - value store of the bounded deque
// Single-port synchronous memory, registered read data, no reset.
// ----------------------------------------------------------------------------
module dbq_store (
	input  logic                           clk,
	input  dbq_pkg::mem_req_t              mem_req,
	output logic [dbq_pkg::DATA_WIDTH-1:0] rd_data
);
	import dbq_pkg::*;

	logic [DATA_WIDTH-1:0] mem_q [CAPACITY];
	logic [DATA_WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (mem_req.wr_en) begin
			mem_q[mem_req.addr] <= mem_req.wdata;
		end
		if (mem_req.rd_en) begin
			rd_data_q <= mem_q[mem_req.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hdl/bounded_deque_with_search.sv]
// ----------------------------------------------------------------------------
// bounded_deque_with_search - double-ended queue over a circular store
// Push/pop/peek at either end, search from the front, remove first match.
// ----------------------------------------------------------------------------
//
//   channel | dir | payload                              | handshake
//   --------+-----+--------------------------------------+-------------
//   req     | in  | operation[2:0], value[31:0]          | valid/ready
//   rsp     | out | data[31:0], found, status[1:0],      | valid/ready
//           |     | entry_count[4:0]                     |
//
// Steps: push, pop and peek pass an accept state (store read) and an exec
//   state (store write or result). Contains adds a read and a compare state
//   per entry from the front up to a hit or the last entry. Remove adds a
//   read and a write state per entry moved behind the hit, and a last read.
//   The single store port (one access a cycle, registered read) sets these.
// Reset: arst_n clears the state machine, front slot, count and result
//   valid; the store is not cleared, entries are only used once written.
// Stalls: the result sits in an output register; a new transaction is
//   taken while it waits. Completion of the next one holds until it drains.
// ----------------------------------------------------------------------------
module bounded_deque_with_search (
	input  logic       clk,
	input  logic       arst_n,
	dbq_req_if.sink    req,
	dbq_rsp_if.source  rsp
);
	import dbq_pkg::*;

	// control state
	state_t             state_q, state_d;
	logic [ADDR_W-1:0]  front_q, front_n;
	logic [COUNT_W-1:0] count_q, count_n;
	logic [COUNT_W-1:0] idx_q, idx_n;     // search position, then shift position

	// latched transaction
	op_t                   op_q;
	logic [DATA_WIDTH-1:0] val_q;

	// result register
	logic                   out_valid_q;
	logic [OUT_DATA_W-1:0]  out_data_q;
	logic                   out_found_q;
	status_t                out_status_q;
	logic [OUT_COUNT_W-1:0] out_count_q;

	// store port
	mem_req_t              mem_req;
	logic                  mem_wr_raw;
	logic [DATA_WIDTH-1:0] rd_data;

	// per-cycle results of the control logic
	logic                  fin;       // this cycle completes the transaction
	logic                  out_free;  // result register can take a new value
	logic                  commit;    // state updates may take effect
	logic [OUT_DATA_W-1:0] res_data;
	logic                  res_found;
	status_t               res_status;

	// condition flags
	logic is_empty, is_full, is_match, srch_last, shift_done, is_search_op;
	logic [COUNT_W-1:0] idx_inc;
	op_t  req_op;

	assign req_op       = op_t'(req.operation);
	assign is_empty     = (count_q == '0);
	assign is_full      = (count_q == COUNT_W'(CAPACITY));
	assign is_match     = (rd_data == val_q);
	assign idx_inc      = idx_q + COUNT_W'(1);
	assign srch_last    = (idx_inc == count_q);
	assign shift_done   = (idx_inc >= count_q);
	assign is_search_op = (op_q == OP_CONTAINS) || (op_q == OP_REMOVE);
	assign out_free     = !out_valid_q || rsp.ready;
	assign commit       = !fin || out_free;

	assign req.ready = (state_q == ST_IDLE);

	dbq_store u_store (
		.clk     (clk),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (is_search_op && !is_empty) begin
					state_d = ST_SRCH_RD;
				end else if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_SRCH_RD: begin
				state_d = ST_SRCH_CMP;
			end
			ST_SRCH_CMP: begin
				if (is_match && op_q == OP_REMOVE) begin
					state_d = ST_SHIFT_RD;
				end else if (fin) begin
					if (out_free) begin
						state_d = ST_IDLE;
					end
				end else begin
					state_d = ST_SRCH_RD;
				end
			end
			ST_SHIFT_RD: begin
				if (fin) begin
					if (out_free) begin
						state_d = ST_IDLE;
					end
				end else begin
					state_d = ST_SHIFT_WR;
				end
			end
			ST_SHIFT_WR: begin
				state_d = ST_SHIFT_RD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---------------- datapath control and results ----------------
	always_comb begin
		mem_req.rd_en = 1'b0;
		mem_wr_raw    = 1'b0;
		mem_req.addr  = front_q;
		mem_req.wdata = val_q;
		fin           = 1'b0;
		res_data      = '0;
		res_found     = 1'b0;
		res_status    = STAT_OK;
		front_n       = front_q;
		count_n       = count_q;
		idx_n         = idx_q;
		case (state_q)
			ST_IDLE: begin
				// fetch the end value early; pops and peeks use it next cycle
				idx_n = '0;
				if (req.valid) begin
					mem_req.rd_en = 1'b1;
					if (req_op == OP_POP_BACK || req_op == OP_PEEK_BACK) begin
						mem_req.addr = slot_of(front_q, count_q - COUNT_W'(1));
					end
				end
			end
			ST_EXEC: begin
				case (op_q)
					OP_PUSH_FRONT, OP_PUSH_BACK: begin
						fin = 1'b1;
						if (is_full) begin
							res_status = STAT_FULL;
						end else begin
							mem_wr_raw = 1'b1;
							count_n    = count_q + COUNT_W'(1);
							if (op_q == OP_PUSH_FRONT) begin
								front_n = (front_q == '0) ? ADDR_W'(CAPACITY - 1)
									: front_q - ADDR_W'(1);
								mem_req.addr = front_n;
							end else begin
								mem_req.addr = slot_of(front_q, count_q);
							end
						end
					end
					OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
						fin = 1'b1;
						if (is_empty) begin
							res_status = STAT_EMPTY;
						end else begin
							res_data = OUT_DATA_W'(rd_data);
							if (op_q == OP_POP_FRONT) begin
								front_n = (front_q == ADDR_W'(CAPACITY - 1)) ? '0
									: front_q + ADDR_W'(1);
								count_n = count_q - COUNT_W'(1);
							end else if (op_q == OP_POP_BACK) begin
								count_n = count_q - COUNT_W'(1);
							end
						end
					end
					default: begin
						// contains / remove: nothing to scan when empty
						fin = is_empty;
					end
				endcase
			end
			ST_SRCH_RD: begin
				mem_req.rd_en = 1'b1;
				mem_req.addr  = slot_of(front_q, idx_q);
			end
			ST_SRCH_CMP: begin
				if (is_match) begin
					if (op_q == OP_CONTAINS) begin
						fin       = 1'b1;
						res_found = 1'b1;
					end
				end else if (srch_last) begin
					fin = 1'b1;
				end else begin
					idx_n = idx_inc;
				end
			end
			ST_SHIFT_RD: begin
				if (shift_done) begin
					fin       = 1'b1;
					res_found = 1'b1;
					count_n   = count_q - COUNT_W'(1);
				end else begin
					mem_req.rd_en = 1'b1;
					mem_req.addr  = slot_of(front_q, idx_inc);
				end
			end
			ST_SHIFT_WR: begin
				// close the gap: entry idx takes the value behind it
				mem_wr_raw    = 1'b1;
				mem_req.addr  = slot_of(front_q, idx_q);
				mem_req.wdata = rd_data;
				idx_n         = idx_inc;
			end
			default: begin
			end
		endcase
		mem_req.wr_en = mem_wr_raw && commit;
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				front_q <= front_n;
				count_q <= count_n;
			end
			if (fin && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q  <= req_op;
			val_q <= DATA_WIDTH'(req.value);
		end
		idx_q <= idx_n;
		if (fin && out_free) begin
			out_data_q   <= res_data;
			out_found_q  <= res_found;
			out_status_q <= res_status;
			out_count_q  <= OUT_COUNT_W'(count_n);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.data        = out_data_q;
	assign rsp.found       = out_found_q;
	assign rsp.status      = out_status_q;
	assign rsp.entry_count = out_count_q;

	// ---------------- assertions ----------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_single_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.rd_en && mem_req.wr_en))
		else $error("store read and written in one cycle");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && fin && out_free && !is_full
			&& (op_q == OP_PUSH_FRONT || op_q == OP_PUSH_BACK))
		|=> count_q == $past(count_q) + COUNT_W'(1))
		else $error("push did not add one entry");

	a_shift_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT_RD || state_q == ST_SHIFT_WR) |-> !is_empty)
		else $error("gap closing with an empty deque");

endmodule

[tb/sv/tb_bounded_deque_with_search.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_deque_with_search - self-checking bench for the bounded deque
// Drives operations through the request channel in random bursts and checks
// each response against a shadow deque kept in a small scoreboard class.
// Directed corner cases first, then biased random traffic with receiver
// stalls, one long back-pressure hold and one full drain mid-run.
// ----------------------------------------------------------------------------
module tb_bounded_deque_with_search;
	import dbq_pkg::*;

	// one response as the block should present it
	typedef struct packed {
		logic [OUT_DATA_W-1:0]  data;
		logic                   found;
		status_t                status;
		logic [OUT_COUNT_W-1:0] entry_count;
	} reply_t;

	// Shadow deque: same circular store, front slot and count as the block.
	// Every accepted transaction is applied here and its response queued.
	class deque_mirror;
		logic [DATA_WIDTH-1:0] store [CAPACITY];
		int front;
		int count;
		int errors;
		reply_t awaited_replies[$];

		function new();
			front  = 0;
			count  = 0;
			errors = 0;
		endfunction

		function int slot(int k);
			return (front + k) % CAPACITY;
		endfunction

		function int pending();
			return awaited_replies.size();
		endfunction

		function void note_op(op_t op, logic [IN_VALUE_W-1:0] value);
			reply_t r;
			logic [DATA_WIDTH-1:0] v;
			int hit;
			int k;
			int s;
			v   = value[DATA_WIDTH-1:0];
			r   = '0;
			hit = -1;
			case (op)
				OP_PUSH_FRONT, OP_PUSH_BACK: begin
					if (count >= CAPACITY) begin
						r.status = STAT_FULL;
					end else begin
						if (op == OP_PUSH_FRONT) begin
							front = (front + CAPACITY - 1) % CAPACITY;
							store[front] = v;
						end else begin
							store[slot(count)] = v;
						end
						count++;
					end
				end
				OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
					if (count == 0) begin
						r.status = STAT_EMPTY;
					end else begin
						s = (op == OP_POP_FRONT || op == OP_PEEK_FRONT) ? front : slot(count - 1);
						r.data = OUT_DATA_W'(store[s]);
						if (op == OP_POP_FRONT) begin
							front = (front + 1) % CAPACITY;
							count--;
						end else if (op == OP_POP_BACK) begin
							count--;
						end
					end
				end
				default: begin
					// contains / remove: first match from the front
					for (k = 0; k < count && hit < 0; k++) begin
						if (store[slot(k)] == v) begin
							hit = k;
						end
					end
					if (hit >= 0) begin
						r.found = 1'b1;
						if (op == OP_REMOVE) begin
							for (k = hit; k + 1 < count; k++) begin
								store[slot(k)] = store[slot(k + 1)];
							end
							count--;
						end
					end
				end
			endcase
			r.entry_count = OUT_COUNT_W'(count);
			awaited_replies.push_back(r);
		endfunction

		function void same_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] data, logic found,
			logic [STATUS_W-1:0] status, logic [OUT_COUNT_W-1:0] entry_count);
			reply_t e;
			if (awaited_replies.size() == 0) begin
				$error("response with nothing outstanding: data %0h status %0d count %0d",
					data, status, entry_count);
				errors++;
				return;
			end
			e = awaited_replies.pop_front();
			same_field("data", 32'(e.data), 32'(data));
			same_field("found", 32'(e.found), 32'(found));
			same_field("status", 32'(e.status), 32'(status));
			same_field("entry_count", 32'(e.entry_count), 32'(entry_count));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   hold_request;   // set once by stimulus, seen by the receiver

	deque_mirror mirror = new();

	dbq_req_if req ();
	dbq_rsp_if rsp ();

	bounded_deque_with_search dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Offer one transaction and hold it until the block takes it. ready is
	// read right after the edge, i.e. the value the edge itself sampled.
	task automatic offer(op_t op, logic [IN_VALUE_W-1:0] value);
		req.valid     <= 1'b1;
		req.operation <= op;
		req.value     <= value;
		do @(posedge clk); while (req.ready !== 1'b1);
		mirror.note_op(op, value);
	endtask

	// Gap between bursts; the length given is never zero, so valid never
	// drops and rises within the same step.
	task automatic idle_sender(int cycles);
		req.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Stop sending until every outstanding response has come back.
	task automatic drain();
		req.valid <= 1'b0;
		do @(posedge clk); while (mirror.pending() != 0);
	endtask

	// ------------------------------------------------------------------
	// Receiver: checks on every accepted response, then picks next ready.
	// Stall pattern switches between always-ready, coin-flip, mostly-ready
	// and a fixed 1-in-4 cadence; a hold request forces a long stall so
	// the output register fills and the request side backs up.
	// ------------------------------------------------------------------
	initial begin
		int hold_left;
		int pattern_left;
		int stall_mode;
		int tick;
		bit hold_taken;
		logic rdy;
		hold_left    = 0;
		pattern_left = 0;
		stall_mode   = 0;
		tick         = 0;
		hold_taken   = 1'b0;
		rsp.ready    <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				mirror.check_result(rsp.data, rsp.found, rsp.status, rsp.entry_count);
			end
			tick++;
			if (hold_request && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = 250;
			end
			if (pattern_left == 0) begin
				stall_mode   = $urandom_range(0, 3);
				pattern_left = $urandom_range(10, 80);
			end
			pattern_left--;
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				case (stall_mode)
					0: rdy = 1'b1;
					1: rdy = 1'($urandom_range(0, 1));
					2: rdy = ($urandom_range(0, 3) != 0);
					default: rdy = (tick % 4 == 0);
				endcase
			end
			rsp.ready <= rdy;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		logic [IN_VALUE_W-1:0] pool [6];
		logic [IN_VALUE_W-1:0] v;
		op_t op;
		int i;
		int n;
		int r;
		int bias;
		int bias_left;
		int burst_left;

		arst_n        <= 1'b0;
		req.valid     <= 1'b0;
		req.operation <= OP_PUSH_FRONT;
		req.value     <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every read-type op on an empty deque (empty status,
		// data zero), search and remove on empty, then fill to capacity
		// from both ends with extreme values and a duplicate, overflow at
		// both ends, a search hit and a remove that closes a mid gap.
		offer(OP_PEEK_FRONT, '1);
		offer(OP_PEEK_BACK, '0);
		offer(OP_POP_FRONT, 32'h5555_5555);
		offer(OP_POP_BACK, 32'hAAAA_AAAA);
		offer(OP_CONTAINS, '0);
		offer(OP_REMOVE, '1);
		for (i = 0; i < CAPACITY; i++) begin
			if (i == 0)
				v = '0;
			else if (i == 1)
				v = '1;
			else if (i == 7 || i == 12)
				v = 32'hDEAD_BEEF;
			else
				v = 32'h1 << (i * 2);
			offer((i % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK, v);
		end
		offer(OP_PUSH_FRONT, 32'h1234_5678);
		offer(OP_PUSH_BACK, 32'h8765_4321);
		offer(OP_CONTAINS, '1);
		offer(OP_REMOVE, 32'hDEAD_BEEF);
		offer(OP_POP_FRONT, '0);
		offer(OP_POP_BACK, '0);
		drain();

		// Random: phases biased toward filling, draining or neither, values
		// mostly from a small pool so searches and removes hit often.
		bias_left  = 0;
		burst_left = $urandom_range(1, 30);
		for (n = 0; n < 1100; n++) begin
			if (bias_left == 0) begin
				bias      = $urandom_range(0, 2);
				bias_left = $urandom_range(20, 60);
				for (i = 0; i < 6; i++) begin
					pool[i] = $urandom();
				end
			end
			bias_left--;

			r = $urandom_range(0, 99);
			case (bias)
				0: op = (r < 55) ? op_t'($urandom_range(0, 1)) : op_t'($urandom_range(2, 7));
				1: begin
					if (r < 45)
						op = ($urandom_range(0, 1) != 0) ? OP_POP_BACK : OP_POP_FRONT;
					else if (r < 65)
						op = OP_REMOVE;
					else
						op = op_t'($urandom_range(0, 7));
				end
				default: op = op_t'($urandom_range(0, 7));
			endcase

			r = $urandom_range(0, 9);
			if (r < 6)
				v = pool[$urandom_range(0, 5)];
			else if (r < 8)
				v = $urandom();
			else
				v = (r == 8) ? '0 : '1;

			// long receiver hold while the sender keeps pushing in
			if (n == 300) begin
				hold_request = 1'b1;
			end
			// one full pause with everything drained
			if (n == 700) begin
				drain();
			end

			if (burst_left == 0) begin
				idle_sender($urandom_range(1, 12));
				burst_left = $urandom_range(1, 30);
			end
			burst_left--;
			offer(op, v);
		end

		// Remove on a full deque is the slowest op; the extra wait catches any
		// stray response.
		drain();
		repeat (100) @(posedge clk);
		if (mirror.errors == 0 && mirror.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Watchdog: a time limit several times the slowest legal run.
	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
